### design/cstl_pkg.sv
// Shared types, token class codes and keyword tables for the token lexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cstl_pkg;

    localparam int LEN_BITS     = 16;
    localparam int OUT_LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam int KW_NUM = 7;
    localparam logic [KW_NUM-1:0] KW_ALL = {KW_NUM{1'b1}};

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef logic [4:0] class_t;

    localparam class_t CL_IDENT  = 5'd0;
    localparam class_t CL_INT    = 5'd1;
    localparam class_t CL_REAL   = 5'd2;
    localparam class_t CL_STRING = 5'd3;
    localparam class_t CL_TYPE   = 5'd4;
    localparam class_t CL_ADD    = 5'd5;
    localparam class_t CL_MUL    = 5'd6;
    localparam class_t CL_REL    = 5'd7;
    localparam class_t CL_OR     = 5'd8;
    localparam class_t CL_AND    = 5'd9;
    localparam class_t CL_NOT    = 5'd10;
    localparam class_t CL_EQNE   = 5'd11;
    localparam class_t CL_SEMI   = 5'd12;
    localparam class_t CL_COMMA  = 5'd13;
    localparam class_t CL_LPAR   = 5'd14;
    localparam class_t CL_RPAR   = 5'd15;
    localparam class_t CL_LBRACE = 5'd16;
    localparam class_t CL_RBRACE = 5'd17;
    localparam class_t CL_ASSIGN = 5'd18;
    localparam class_t CL_IF     = 5'd19;
    localparam class_t CL_WHILE  = 5'd20;
    localparam class_t CL_RETURN = 5'd21;
    localparam class_t CL_ELSE   = 5'd22;
    localparam class_t CL_END    = 5'd23;
    localparam class_t CL_ERROR  = 5'd24;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_REAL,
        M_STRING,
        M_RELOP,
        M_BAR,
        M_AMP,
        M_BANG,
        M_EQ
    } mode_t;

    typedef struct packed {
        class_t                  tclass;
        logic [OUT_LEN_BITS-1:0] tlen;
        logic                    last;
    } record_t;

    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd5, 3'd4, 3'd2, 3'd5, 3'd6, 3'd4};
    localparam class_t KW_CLASS [KW_NUM] =
        '{CL_TYPE, CL_TYPE, CL_TYPE, CL_IF, CL_WHILE, CL_RETURN, CL_ELSE};

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Narrow the keyword candidates by the letter at position pos.
    function automatic logic [KW_NUM-1:0] kw_filter(input logic [KW_NUM-1:0] cands,
                                                    input logic [LEN_BITS-1:0] pos,
                                                    input logic [7:0] c);
        logic [KW_NUM-1:0] r;
        r = '0;
        for (int k = 0; k < KW_NUM; k++)
        begin
            if (cands[k] && (pos < LEN_BITS'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == c))
            begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    // First surviving keyword of matching length wins, else plain identifier.
    function automatic class_t ident_class(input logic [KW_NUM-1:0] cands,
                                           input logic [LEN_BITS-1:0] len);
        class_t r;
        r = CL_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            if (cands[k] && (len == LEN_BITS'(KW_LEN[k])))
            begin
                r = KW_CLASS[k];
            end
        end
        return r;
    endfunction

    function automatic logic [OUT_LEN_BITS-1:0] out_len(input logic [LEN_BITS-1:0] l);
        logic [31:0] w;
        w = 32'(l);
        return (w > 32'h0000FFFF) ? {OUT_LEN_BITS{1'b1}} : w[OUT_LEN_BITS-1:0];
    endfunction

endpackage

### design/cstl_scan.sv
// Scanner state machine: one character per step, up to two token records.
// Depends on cstl_pkg.
`timescale 1ns / 1ps

module cstl_scan
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    output cstl_pkg::record_t rec0,
    output cstl_pkg::record_t rec1,
    output logic [1:0]        nrec
);

    import cstl_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [KW_NUM-1:0]    cand_reg, cand_next;

    mode_t                idle_mode;
    logic [LEN_BITS-1:0]  idle_len;
    logic [KW_NUM-1:0]    idle_cands;
    logic                 idle_emit;
    class_t               idle_cls;

    logic                 a_emit, b_emit, again;
    class_t               a_cls;
    logic [LEN_BITS-1:0]  a_len, len_inc;
    record_t              rec_a, rec_b;

    // Decode a character seen between tokens.
    always_comb
    begin
        idle_mode  = M_IDLE;
        idle_len   = '0;
        idle_cands = KW_ALL;
        idle_emit  = 1'b0;
        idle_cls   = CL_ERROR;
        if (is_letter(ch))
        begin
            idle_mode  = M_IDENT;
            idle_cands = kw_filter(KW_ALL, '0, ch);
            idle_len   = LEN_BITS'(1);
        end
        else if (is_digit(ch))
        begin
            idle_mode = M_INT;
            idle_len  = LEN_BITS'(1);
        end
        else if (ch == "\"")
        begin
            idle_mode = M_STRING;
            idle_len  = LEN_BITS'(1);
        end
        else
        begin
            case (ch)
                "+", "-":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_ADD;
                end
                "*", "/":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_MUL;
                end
                "<", ">": idle_mode = M_RELOP;
                "|":      idle_mode = M_BAR;
                "&":      idle_mode = M_AMP;
                "!":      idle_mode = M_BANG;
                "=":      idle_mode = M_EQ;
                ";":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_SEMI;
                end
                ",":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_COMMA;
                end
                "(":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_LPAR;
                end
                ")":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_RPAR;
                end
                "{":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_LBRACE;
                end
                "}":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_RBRACE;
                end
                " ", "\t":
                begin
                    idle_emit = 1'b0;
                end
                "$":
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_END;
                end
                default:
                begin
                    idle_emit = 1'b1;
                    idle_cls  = CL_ERROR;
                end
            endcase
        end
    end

    // Continue the open token, then rescan from idle where needed.
    always_comb
    begin
        len_inc   = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
        mode_next = mode_reg;
        len_next  = len_reg;
        cand_next = cand_reg;
        a_emit    = 1'b0;
        a_cls     = CL_ERROR;
        a_len     = len_reg;
        again     = 1'b0;
        case (mode_reg)
            M_IDENT:
            begin
                if (is_letter(ch) || is_digit(ch))
                begin
                    cand_next = kw_filter(cand_reg, len_reg, ch);
                    len_next  = len_inc;
                end
                else
                begin
                    a_emit = 1'b1;
                    a_cls  = ident_class(cand_reg, len_reg);
                    again  = 1'b1;
                end
            end
            M_INT:
            begin
                if (is_digit(ch))
                begin
                    len_next = len_inc;
                end
                else if (ch == ".")
                begin
                    len_next  = len_inc;
                    mode_next = M_REAL;
                end
                else
                begin
                    a_emit = 1'b1;
                    a_cls  = CL_INT;
                    again  = 1'b1;
                end
            end
            M_REAL:
            begin
                if (is_digit(ch))
                begin
                    len_next = len_inc;
                end
                else
                begin
                    a_emit = 1'b1;
                    a_cls  = CL_REAL;
                    again  = 1'b1;
                end
            end
            M_STRING:
            begin
                len_next = len_inc;
                a_len    = len_inc;
                if (ch == "\"")
                begin
                    a_emit    = 1'b1;
                    a_cls     = CL_STRING;
                    mode_next = M_IDLE;
                end
                else if (ch == "$")
                begin
                    a_emit    = 1'b1;
                    a_cls     = CL_ERROR;
                    mode_next = M_IDLE;
                end
            end
            M_RELOP, M_BAR, M_AMP, M_BANG, M_EQ:
            begin
                mode_next = M_IDLE;
                a_emit    = 1'b1;
                a_len     = LEN_BITS'(1);
                case (mode_reg)
                    M_RELOP:
                    begin
                        a_cls = CL_REL;
                        again = (ch != "=");
                    end
                    M_BAR:
                    begin
                        a_cls = (ch == "|") ? CL_OR : CL_ERROR;
                        again = (ch != "|");
                    end
                    M_AMP:
                    begin
                        a_cls = (ch == "&") ? CL_AND : CL_ERROR;
                        again = (ch != "&");
                    end
                    M_BANG:
                    begin
                        a_cls = (ch == "=") ? CL_EQNE : CL_NOT;
                        again = (ch != "=");
                    end
                    default:
                    begin
                        a_cls = (ch == "=") ? CL_EQNE : CL_ASSIGN;
                        again = (ch != "=");
                    end
                endcase
                if (!again)
                begin
                    a_len = LEN_BITS'(2);
                end
            end
            default:
            begin
                again = 1'b1;
            end
        endcase

        b_emit = 1'b0;
        if (again)
        begin
            mode_next = idle_mode;
            len_next  = idle_len;
            cand_next = idle_cands;
            b_emit    = idle_emit;
        end
        if (mode_next == M_IDLE)
        begin
            len_next  = '0;
            cand_next = KW_ALL;
        end
    end

    always_comb
    begin
        rec_a.tclass = a_cls;
        rec_a.tlen   = out_len(a_len);
        rec_a.last   = !b_emit;
        rec_b.tclass = idle_cls;
        rec_b.tlen   = OUT_LEN_BITS'(1);
        rec_b.last   = 1'b1;
        if (a_emit)
        begin
            rec0 = rec_a;
            rec1 = rec_b;
        end
        else
        begin
            rec0 = rec_b;
            rec1 = rec_b;
        end
        nrec = {1'b0, a_emit} + {1'b0, b_emit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            cand_reg <= KW_ALL;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            cand_reg <= cand_next;
        end
    end

endmodule

### design/cstl_outq.sv
// Result queue: takes zero, one or two records a cycle, hands out one.
// Depends on cstl_pkg.
`timescale 1ns / 1ps

module cstl_outq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_n,
    input  cstl_pkg::record_t            push0,
    input  cstl_pkg::record_t            push1,
    input  logic                         pop,
    output cstl_pkg::record_t            head,
    output logic [cstl_pkg::OQ_CW-1:0]   count
);

    import cstl_pkg::*;

    record_t            mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_reg, wr_next;
    logic [OQ_AW-1:0]   rd_reg, rd_next;
    logic [OQ_CW-1:0]   count_reg, count_next;
    logic [OQ_AW-1:0]   wr_plus1;

    assign wr_plus1 = wr_reg + 1'b1;
    assign head     = mem[rd_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_next    = wr_reg + OQ_AW'(push_n);
        rd_next    = rd_reg + OQ_AW'(pop);
        count_next = count_reg + OQ_CW'(push_n) - OQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/c_subset_token_lexer.sv
// Token lexer for a small C subset: one source byte per beat in, token records out.
// Built from cstl_scan and cstl_outq; depends on cstl_pkg.
//
// Input channel: in_valid / in_stall / char_code, one byte per beat; '$' ends the text.
// Output channel: out_valid / out_stall / token_class, token_length, last_of_run;
//   one beat per finished token, last_of_run marks the final record of a byte.
// A byte gives zero, one or two records. Each byte passes through the input
//   register, then the scanner writes its records into the queue.
// Throughput is one byte per cycle while the output keeps up; the single-record
//   output port sets the limit where bytes give two records.
// The input register feeds the scanner when the 4-entry result queue has room
//   for two records after this cycle's pop; otherwise in_stall rises and the
//   byte waits in the input register.
// When out_stall is high the head record holds and the queue fills; input then
//   stalls once it cannot take two more records.
// Reset puts the scanner between tokens with an empty queue and no pending byte.
`timescale 1ns / 1ps

module c_subset_token_lexer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cstl_pkg::class_t      token_class,
    output logic [15:0]           token_length,
    output logic                  last_of_run
);

    import cstl_pkg::*;

    logic               full_reg, full_next;
    logic [7:0]         ch_reg;
    logic               room, step, pop;
    record_t            rec0, rec1, head;
    logic [1:0]         nrec;
    logic [OQ_CW-1:0]   count;

    assign pop  = out_valid && !out_stall;
    assign room = (count <= OQ_CW'(OQ_DEPTH - 2)) ||
                  (pop && (count == OQ_CW'(OQ_DEPTH - 1)));
    assign step = full_reg && room;

    assign in_stall  = full_reg && !room;
    assign full_next = in_stall ? full_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg <= char_code;
        end
    end

    cstl_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (ch_reg),
        .rec0  (rec0),
        .rec1  (rec1),
        .nrec  (nrec)
    );

    cstl_outq u_outq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (step ? nrec : 2'd0),
        .push0  (rec0),
        .push1  (rec1),
        .pop    (pop),
        .head   (head),
        .count  (count)
    );

    assign out_valid    = (count != '0);
    assign token_class  = head.tclass;
    assign token_length = head.tlen;
    assign last_of_run  = head.last;

endmodule

### design/cstl_checker.sv
// Port-level checks on the token lexer output channel, bound to the top level.
// Depends on cstl_pkg and c_subset_token_lexer.
`timescale 1ns / 1ps

module cstl_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             out_valid,
    input  logic             out_stall,
    input  cstl_pkg::class_t token_class,
    input  logic [15:0]      token_length,
    input  logic             last_of_run
);

    import cstl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_class) &&
            $stable(token_length) && $stable(last_of_run))
        else $error("stalled output record changed");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_class == CL_END) |-> (token_length == 16'd1) && last_of_run)
        else $error("end record not final or wrong length");

    a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((token_class == CL_OR) || (token_class == CL_AND))
            |-> (token_length == 16'd2))
        else $error("logical operator length not two");

    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((token_class == CL_SEMI) || (token_class == CL_COMMA) ||
            (token_class == CL_LPAR) || (token_class == CL_RPAR) ||
            (token_class == CL_LBRACE) || (token_class == CL_RBRACE) ||
            (token_class == CL_NOT) || (token_class == CL_ASSIGN) ||
            (token_class == CL_ADD) || (token_class == CL_MUL))
            |-> (token_length == 16'd1))
        else $error("single character token length not one");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_class <= CL_ERROR) && (token_length != 16'd0))
        else $error("output record class or length out of range");

endmodule

bind c_subset_token_lexer cstl_checker u_cstl_checker (.*);
